>>> hdl/earliest_expiry_batch_consumer_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the earliest expiry batch consumer
// Clocked on clock and disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef EARLIEST_EXPIRY_BATCH_CONSUMER_ASSERT_SVH
`define EARLIEST_EXPIRY_BATCH_CONSUMER_ASSERT_SVH

// same-cycle implication
`define EEBC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("eebc assertion failed");

// next-cycle implication
`define EEBC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("eebc assertion failed");

`endif

>>> hdl/eebc_pkg.sv
// ---------------------------------------------------------------------------
// eebc_pkg
// Types, widths and controller/datapath command codes.
// ---------------------------------------------------------------------------
package eebc_pkg;

   localparam int HEAP_DEPTH = 1024;
   localparam int IDX_W      = $clog2(HEAP_DEPTH);
   localparam int FILL_W     = $clog2(HEAP_DEPTH + 1);
   localparam int CHILD_W    = IDX_W + 2;
   localparam int UNIT_W     = 16;
   localparam int LIFE_W     = 16;
   localparam int TICK_W     = 32;
   localparam int EXP_W      = 33;
   localparam int TOTAL_W    = 32;

   typedef struct packed {
      logic [UNIT_W-1:0] units;
      logic [EXP_W-1:0]  expiry;
   } slot_type;

   typedef enum logic [3:0] {
      S_IDLE, S_INS, S_SU_TEST, S_SU_CMP, S_EXP_RD, S_EXP_CMP, S_RM_START,
      S_RM_LOAD, S_SD_LEFT, S_SD_RIGHT, S_SD_CMP, S_SD_MOVE, S_FINISH
   } state_type;

   typedef enum logic [2:0] {RD_PARENT, RD_ROOT, RD_LAST, RD_LEFT, RD_RIGHT} rd_sel_type;
   typedef enum logic [1:0] {WR_CUR, WR_RDATA, WR_BEST, WR_ROOT_DEC} wr_sel_type;
   typedef enum logic [2:0] {POS_HOLD, POS_FILL, POS_PARENT, POS_ZERO, POS_BEST} pos_op_type;

   typedef struct packed {
      logic       accept;
      logic       mem_rd;
      rd_sel_type rd_sel;
      logic       mem_wr;
      wr_sel_type wr_sel;
      pos_op_type pos_op;
      logic       fill_inc;
      logic       fill_dec;
      logic       set_drop;
      logic       consume;
      logic       cur_load;
      logic       best_init;
      logic       best_right;
      logic       finish;
   } ctl_type;

   typedef struct packed {
      logic units_nz;
      logic heap_full;
      logic fill_zero;
      logic fill_one;
      logic pos_zero;
      logic parent_gt;
      logic root_expired;
      logic root_last;
      logic left_in;
      logic right_in;
      logic best_child;
      logic out_free;
   } sts_type;

endpackage

>>> hdl/eebc_req_if.sv
// ---------------------------------------------------------------------------
// eebc_req_if
// Input channel: one tick with an optional batch.
// ---------------------------------------------------------------------------
interface eebc_req_if;
   import eebc_pkg::*;

   logic              valid;
   logic              ready;
   logic [UNIT_W-1:0] batch_units;
   logic [LIFE_W-1:0] shelf_life;

   modport source (output valid, output batch_units, output shelf_life, input ready);
   modport sink   (input valid, input batch_units, input shelf_life, output ready);
endinterface

>>> hdl/eebc_rsp_if.sv
// ---------------------------------------------------------------------------
// eebc_rsp_if
// Result channel: consumption report for one tick.
// ---------------------------------------------------------------------------
interface eebc_rsp_if;
   import eebc_pkg::*;

   logic               valid;
   logic               ready;
   logic               unit_used;
   logic [TOTAL_W-1:0] total_used;
   logic [FILL_W-1:0]  batches_held;
   logic               batch_dropped;

   modport source (output valid, output unit_used, output total_used,
                   output batches_held, output batch_dropped, input ready);
   modport sink   (input valid, input unit_used, input total_used,
                   input batches_held, input batch_dropped, output ready);
endinterface

>>> hdl/eebc_ctrl.sv
// ---------------------------------------------------------------------------
// eebc_ctrl
// Sequencer for insert, expiry purge, consume and heap sifts.
// ---------------------------------------------------------------------------
module eebc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  eebc_pkg::sts_type sts,
   output eebc_pkg::ctl_type ctl
);
   import eebc_pkg::*;

   state_type state_ff, state_in;
   logic      consume_mode_ff, consume_mode_in;
   state_type done_state;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         consume_mode_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         consume_mode_ff <= consume_mode_in;
      end
   end

   // where a removal goes once it ends, with or without a sift-down
   assign done_state = consume_mode_ff ? S_FINISH : S_EXP_RD;

   always_comb begin
      state_in        = state_ff;
      consume_mode_in = consume_mode_ff;
      req_ready       = 1'b0;
      ctl             = '0;
      ctl.rd_sel      = RD_ROOT;
      ctl.wr_sel      = WR_CUR;
      ctl.pos_op      = POS_HOLD;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.accept = 1'b1;
               state_in   = S_INS;
            end
         end
         S_INS: begin
            if (!sts.units_nz) begin
               state_in = S_EXP_RD;
            end else if (sts.heap_full) begin
               ctl.set_drop = 1'b1;
               state_in     = S_EXP_RD;
            end else begin
               ctl.pos_op   = POS_FILL;
               ctl.fill_inc = 1'b1;
               state_in     = S_SU_TEST;
            end
         end
         S_SU_TEST: begin
            if (sts.pos_zero) begin
               ctl.mem_wr = 1'b1;
               state_in   = S_EXP_RD;
            end else begin
               ctl.mem_rd = 1'b1;
               ctl.rd_sel = RD_PARENT;
               state_in   = S_SU_CMP;
            end
         end
         S_SU_CMP: begin
            ctl.mem_wr = 1'b1;
            if (sts.parent_gt) begin
               ctl.wr_sel = WR_RDATA;
               ctl.pos_op = POS_PARENT;
               state_in   = S_SU_TEST;
            end else begin
               state_in   = S_EXP_RD;
            end
         end
         S_EXP_RD: begin
            if (sts.fill_zero) begin
               state_in = S_FINISH;
            end else begin
               ctl.mem_rd = 1'b1;
               state_in   = S_EXP_CMP;
            end
         end
         S_EXP_CMP: begin
            if (sts.root_expired) begin
               consume_mode_in = 1'b0;
               state_in        = S_RM_START;
            end else begin
               ctl.consume = 1'b1;
               if (sts.root_last) begin
                  consume_mode_in = 1'b1;
                  state_in        = S_RM_START;
               end else begin
                  ctl.mem_wr = 1'b1;
                  ctl.wr_sel = WR_ROOT_DEC;
                  state_in   = S_FINISH;
               end
            end
         end
         S_RM_START: begin
            ctl.fill_dec = 1'b1;
            if (sts.fill_one) begin
               state_in = done_state;
            end else begin
               ctl.mem_rd = 1'b1;
               ctl.rd_sel = RD_LAST;
               state_in   = S_RM_LOAD;
            end
         end
         S_RM_LOAD: begin
            ctl.cur_load = 1'b1;
            ctl.pos_op   = POS_ZERO;
            state_in     = S_SD_LEFT;
         end
         S_SD_LEFT: begin
            if (!sts.left_in) begin
               ctl.mem_wr = 1'b1;
               state_in   = done_state;
            end else begin
               ctl.mem_rd = 1'b1;
               ctl.rd_sel = RD_LEFT;
               state_in   = S_SD_RIGHT;
            end
         end
         S_SD_RIGHT: begin
            ctl.best_init = 1'b1;
            if (sts.right_in) begin
               ctl.mem_rd = 1'b1;
               ctl.rd_sel = RD_RIGHT;
               state_in   = S_SD_CMP;
            end else begin
               state_in   = S_SD_MOVE;
            end
         end
         S_SD_CMP: begin
            ctl.best_right = 1'b1;
            state_in       = S_SD_MOVE;
         end
         S_SD_MOVE: begin
            ctl.mem_wr = 1'b1;
            if (sts.best_child) begin
               ctl.wr_sel = WR_BEST;
               ctl.pos_op = POS_BEST;
               state_in   = S_SD_LEFT;
            end else begin
               state_in   = done_state;
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               ctl.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

>>> hdl/eebc_dpath.sv
// ---------------------------------------------------------------------------
// eebc_dpath
// Heap memory, hole-based sift registers, counters and result register.
// ---------------------------------------------------------------------------
`include "earliest_expiry_batch_consumer_assert.svh"

module eebc_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  eebc_pkg::ctl_type            ctl,
   output eebc_pkg::sts_type            sts,
   input  logic [eebc_pkg::UNIT_W-1:0]  req_units,
   input  logic [eebc_pkg::LIFE_W-1:0]  req_life,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_unit_used,
   output logic [eebc_pkg::TOTAL_W-1:0] rsp_total_used,
   output logic [eebc_pkg::FILL_W-1:0]  rsp_batches_held,
   output logic                         rsp_batch_dropped
);
   import eebc_pkg::*;

   slot_type heap_mem [HEAP_DEPTH];
   slot_type rdata_ff;

   logic [FILL_W-1:0]  fill_ff;
   logic [TICK_W-1:0]  tick_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   slot_type           cur_ff;
   slot_type           best_ff;
   logic               best_child_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic               used_ff, dropped_ff;
   logic               rsp_valid_ff;
   logic               out_used_ff, out_dropped_ff;
   logic [TOTAL_W-1:0] out_total_ff;
   logic [FILL_W-1:0]  out_held_ff;

   logic [IDX_W-1:0]   parent_idx;
   logic [CHILD_W-1:0] left_idx, right_idx;
   logic [IDX_W-1:0]   rd_addr, wr_addr;
   slot_type           wr_data;
   slot_type           root_dec;
   logic [EXP_W-1:0]   now_exp;

   assign parent_idx = (pos_ff - 1'b1) >> 1;
   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = left_idx + 1'b1;
   assign now_exp    = EXP_W'(tick_ff);
   assign root_dec   = '{units: rdata_ff.units - 1'b1, expiry: rdata_ff.expiry};

   always_comb begin
      unique case (ctl.rd_sel)
         RD_PARENT: rd_addr = parent_idx;
         RD_ROOT:   rd_addr = '0;
         RD_LAST:   rd_addr = IDX_W'(fill_ff - 1'b1);
         RD_LEFT:   rd_addr = IDX_W'(left_idx);
         RD_RIGHT:  rd_addr = IDX_W'(right_idx);
         default:   rd_addr = '0;
      endcase
   end

   always_comb begin
      wr_addr = pos_ff;
      unique case (ctl.wr_sel)
         WR_CUR:      wr_data = cur_ff;
         WR_RDATA:    wr_data = rdata_ff;
         WR_BEST:     wr_data = best_ff;
         WR_ROOT_DEC: begin
            wr_data = root_dec;
            wr_addr = '0;
         end
         default:     wr_data = cur_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.mem_wr) begin
         heap_mem[wr_addr] <= wr_data;
      end
      if (ctl.mem_rd) begin
         rdata_ff <= heap_mem[rd_addr];
      end
   end

   always_comb begin
      unique case (ctl.pos_op)
         POS_HOLD:   pos_in = pos_ff;
         POS_FILL:   pos_in = IDX_W'(fill_ff);
         POS_PARENT: pos_in = parent_idx;
         POS_ZERO:   pos_in = '0;
         POS_BEST:   pos_in = best_idx_ff;
         default:    pos_in = pos_ff;
      endcase
   end

   // sift payload and result registers
   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (ctl.accept) begin
         cur_ff <= '{units: req_units, expiry: now_exp + EXP_W'(req_life)};
      end else if (ctl.cur_load) begin
         cur_ff <= rdata_ff;
      end
      if (ctl.best_init) begin
         if (rdata_ff.expiry < cur_ff.expiry) begin
            best_ff     <= rdata_ff;
            best_idx_ff <= IDX_W'(left_idx);
         end else begin
            best_ff     <= cur_ff;
         end
      end else if (ctl.best_right && (rdata_ff.expiry < best_ff.expiry)) begin
         best_ff     <= rdata_ff;
         best_idx_ff <= IDX_W'(right_idx);
      end
      if (ctl.finish) begin
         out_used_ff    <= used_ff;
         out_dropped_ff <= dropped_ff;
         out_total_ff   <= total_ff;
         out_held_ff    <= fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         tick_ff       <= '0;
         total_ff      <= '0;
         best_child_ff <= 1'b0;
         used_ff       <= 1'b0;
         dropped_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (ctl.fill_inc) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (ctl.fill_dec) begin
            fill_ff <= fill_ff - 1'b1;
         end
         if (ctl.accept) begin
            used_ff    <= 1'b0;
            dropped_ff <= 1'b0;
         end
         if (ctl.set_drop) begin
            dropped_ff <= 1'b1;
         end
         if (ctl.consume) begin
            used_ff <= 1'b1;
            if (total_ff != '1) begin
               total_ff <= total_ff + 1'b1;
            end
         end
         if (ctl.best_init) begin
            best_child_ff <= rdata_ff.expiry < cur_ff.expiry;
         end else if (ctl.best_right && (rdata_ff.expiry < best_ff.expiry)) begin
            best_child_ff <= 1'b1;
         end
         if (ctl.finish) begin
            rsp_valid_ff <= 1'b1;
            if (tick_ff != '1) begin
               tick_ff <= tick_ff + 1'b1;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.units_nz     = cur_ff.units != '0;
   assign sts.heap_full    = fill_ff == FILL_W'(HEAP_DEPTH);
   assign sts.fill_zero    = fill_ff == '0;
   assign sts.fill_one     = fill_ff == FILL_W'(1);
   assign sts.pos_zero     = pos_ff == '0;
   assign sts.parent_gt    = rdata_ff.expiry > cur_ff.expiry;
   assign sts.root_expired = rdata_ff.expiry <= now_exp;
   assign sts.root_last    = rdata_ff.units == UNIT_W'(1);
   assign sts.left_in      = left_idx < CHILD_W'(fill_ff);
   assign sts.right_in     = right_idx < CHILD_W'(fill_ff);
   assign sts.best_child   = best_child_ff;
   assign sts.out_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_unit_used     = out_used_ff;
   assign rsp_total_used    = out_total_ff;
   assign rsp_batches_held  = out_held_ff;
   assign rsp_batch_dropped = out_dropped_ff;

   `EEBC_ASSERT_IMP(a_fill_bound, 1'b1, fill_ff <= FILL_W'(HEAP_DEPTH))
   `EEBC_ASSERT_IMP(a_fill_onedir, ctl.fill_inc || ctl.fill_dec,
                    !(ctl.fill_inc && ctl.fill_dec))
   `EEBC_ASSERT_IMP(a_wr_live, ctl.mem_wr, FILL_W'(wr_addr) < fill_ff)
   `EEBC_ASSERT_IMP(a_drop_full, ctl.set_drop, fill_ff == FILL_W'(HEAP_DEPTH))
   `EEBC_ASSERT_NEXT(a_finish_valid, ctl.finish, rsp_valid_ff)
endmodule

>>> hdl/earliest_expiry_batch_consumer.sv
// ---------------------------------------------------------------------------
// earliest_expiry_batch_consumer
// Tick-driven batch store: min-heap on expiry, purge, consume one unit.
// ---------------------------------------------------------------------------
//  channel   dir  payload                                          handshake
//  req_chan  in   batch_units, shelf_life                          valid/ready
//  rsp_chan  out  unit_used, total_used, batches_held, batch_dropped valid/ready
//
// One tick at a time through a heap memory with one read and one write port
// (registered read). A tick passes through accept, insert check, root read,
// root compare and finish, with a sift-up when a batch goes in, a removal
// with sift-down for each purged batch, and another when the consumed batch
// empties.
// Reset is synchronous and empties the heap at once; no clearing pass.
// A result waits in the output register while rsp ready is low; the next tick
// is taken meanwhile, and its finish waits until that register is free.
// ---------------------------------------------------------------------------
module earliest_expiry_batch_consumer (
   input  logic       clock,
   input  logic       reset,
   eebc_req_if.sink   req_chan,
   eebc_rsp_if.source rsp_chan
);
   import eebc_pkg::*;

   ctl_type ctl;
   sts_type sts;

   eebc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   eebc_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .req_units         (req_chan.batch_units),
      .req_life          (req_chan.shelf_life),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_unit_used     (rsp_chan.unit_used),
      .rsp_total_used    (rsp_chan.total_used),
      .rsp_batches_held  (rsp_chan.batches_held),
      .rsp_batch_dropped (rsp_chan.batch_dropped)
   );
endmodule
